// ===== src/lve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lve_pkg
// Shared types and constants of the loss vector evaluator.
// ----------------------------------------------------------------------------
package lve_pkg;

  localparam int unsigned MaxElements = 4096;
  localparam int unsigned CountW      = 13;
  localparam int unsigned DivIters    = 64;
  localparam int unsigned DivCntW     = 7;
  localparam logic [63:0] Q24One      = 64'd16777216;
  localparam logic [31:0] Ln2Q32      = 32'hB172_17F8;
  localparam logic [55:0] ValueMax    = {56{1'b1}};
  localparam logic [4:0]  SeriesLastN = 5'd25;

  typedef enum logic [1:0] {
    KIND_MSE = 2'd0,
    KIND_BCE = 2'd1,
    KIND_CCE = 2'd2,
    KIND_RSV = 2'd3
  } lve_kind_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRED    = 3'd1;
  localparam logic [2:0] ST_TARGET  = 3'd2;
  localparam logic [2:0] ST_ONE_HOT = 3'd3;
  localparam logic [2:0] ST_OVF     = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MSE_MUL,
    OP_MSE_TERM,
    OP_ZERO_TERM,
    OP_LN_PREP,
    OP_ZDIV,
    OP_LN_INIT,
    OP_SQ_MUL,
    OP_SQ_CAP,
    OP_T_MUL,
    OP_T_DIV,
    OP_T_ACC,
    OP_A_MUL,
    OP_LN_TERM,
    OP_ACCUM,
    OP_MEAN_DIV,
    OP_RESULT
  } lve_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_MSE_MUL,
    S_MSE_TERM,
    S_ZERO,
    S_LN_PREP,
    S_ZDIV,
    S_ZWAIT,
    S_LN_INIT,
    S_SQ_MUL,
    S_SQ_CAP,
    S_T_MUL,
    S_T_DIV,
    S_T_ACC,
    S_A_MUL,
    S_LN_TERM,
    S_ACCUM,
    S_FINISH,
    S_MEAN_DIV,
    S_MEAN_WAIT,
    S_RESULT
  } lve_state_e;

  typedef struct packed {
    lve_op_e op;
  } lve_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic item_last;
    logic log_path;
    logic mse_path;
    logic series_last;
    logic need_mean;
    logic out_free;
  } lve_status_t;

endpackage

// ===== src/lve_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lve_divider
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module lve_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o,
  output logic [31:0] rem_o
);
  import lve_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [63:0]        qr_q, qr_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        dsr_q, dsr_d;
  logic [32:0]        r_sh;
  logic               ge;

  always_comb begin
    r_sh  = {rem_q, qr_q[63]};
    ge    = r_sh >= {1'b0, dsr_q};
    cnt_d = cnt_q;
    qr_d  = qr_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    if (start_i) begin
      cnt_d = DivCntW'(DivIters);
      qr_d  = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      qr_d  = {qr_q[62:0], ge};
      rem_d = ge ? 32'(r_sh - {1'b0, dsr_q}) : r_sh[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q  <= qr_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = qr_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/lve_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lve_datapath
// Item registers, validation, shared multiplier and divider, log series,
// accumulator and result register.
// ----------------------------------------------------------------------------
module lve_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lve_pkg::lve_cmd_t   cmd_i,
  output lve_pkg::lve_status_t status_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic [31:0]         predicted_i,
  input  logic [31:0]         expected_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [55:0]         loss_value_o,
  output logic [2:0]          status_code_o
);
  import lve_pkg::*;

  lve_kind_e          kind_cfg_q, kind_q;
  logic signed [31:0] p_q, t_q;
  logic               last_q;
  logic [2:0]         err_q;
  logic [1:0]         hot_q;
  logic [63:0]        acc_q;
  logic [CountW-1:0]  cnt_q;
  logic [63:0]        term_q;
  logic [4:0]         k_q;
  logic [30:0]        x_q;
  logic [30:0]        z_q;
  logic [31:0]        z2_q;
  logic [31:0]        ser_t_q;
  logic [32:0]        ser_sum_q;
  logic [4:0]         n_q;
  logic [63:0]        mul_q;
  logic               out_valid_q;
  logic [55:0]        out_loss_q;
  logic [2:0]         out_st_q;

  logic               ce_in, tgt_one, in_t_one;
  logic               div_start, div_busy;
  logic [63:0]        div_dvd, quot;
  logic [31:0]        div_dsr, rem;
  logic [31:0]        mul_a, mul_b;
  logic signed [32:0] diff;
  logic [31:0]        ad;
  logic [23:0]        pc, q;
  logic [4:0]         k_d;
  logic [64:0]        acc_sum;
  logic [33:0]        lnm;
  logic [37:0]        a_val, ln_diff;
  logic [2:0]         err_fin;
  logic               round_up, need_mean;
  logic [64:0]        val;
  logic [55:0]        res_loss;
  logic [2:0]         res_st;
  logic [31:0]        recip;
  logic [5:0]         rsh;
  logic [30:0]        t_quo;

  assign ce_in    = (kind_cfg_q == KIND_BCE) || (kind_cfg_q == KIND_CCE);
  assign in_t_one = 64'(signed'(expected_i)) == Q24One;
  assign tgt_one  = 64'(t_q) == Q24One;

  lve_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    diff = 33'(p_q) - 33'(t_q);
    ad   = diff[32] ? 32'(-diff) : diff[31:0];
    if (p_q < 32'sd1) begin
      pc = 24'd1;
    end else if (p_q > 32'sd16777215) begin
      pc = 24'hFF_FFFF;
    end else begin
      pc = p_q[23:0];
    end
    q = (kind_q == KIND_BCE && !tgt_one) ? 24'(25'h100_0000 - 25'(pc)) : pc;
    k_d = '0;
    for (int i = 1; i < 24; i++) begin
      if (q[i]) k_d = 5'(i);
    end
  end

  // series term over n: multiply by ceil(2^s / n), then shift by s
  always_comb begin
    case (n_q)
      5'd3:    recip = 32'(((64'd1 << 33) + 64'd2) / 64'd3);
      5'd5:    recip = 32'(((64'd1 << 34) + 64'd4) / 64'd5);
      5'd7:    recip = 32'(((64'd1 << 34) + 64'd6) / 64'd7);
      5'd9:    recip = 32'(((64'd1 << 35) + 64'd8) / 64'd9);
      5'd11:   recip = 32'(((64'd1 << 35) + 64'd10) / 64'd11);
      5'd13:   recip = 32'(((64'd1 << 35) + 64'd12) / 64'd13);
      5'd15:   recip = 32'(((64'd1 << 35) + 64'd14) / 64'd15);
      5'd17:   recip = 32'(((64'd1 << 36) + 64'd16) / 64'd17);
      5'd19:   recip = 32'(((64'd1 << 36) + 64'd18) / 64'd19);
      5'd21:   recip = 32'(((64'd1 << 36) + 64'd20) / 64'd21);
      5'd23:   recip = 32'(((64'd1 << 36) + 64'd22) / 64'd23);
      5'd25:   recip = 32'(((64'd1 << 36) + 64'd24) / 64'd25);
      default: recip = '0;
    endcase
    if (n_q < 5'd5) begin
      rsh = 6'd33;
    end else if (n_q < 5'd9) begin
      rsh = 6'd34;
    end else if (n_q < 5'd17) begin
      rsh = 6'd35;
    end else begin
      rsh = 6'd36;
    end
    t_quo = 31'(mul_q >> rsh);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MSE_MUL: begin
        mul_a = ad;
        mul_b = ad;
      end
      OP_SQ_MUL: begin
        mul_a = {1'b0, z_q};
        mul_b = {1'b0, z_q};
      end
      OP_T_MUL: begin
        mul_a = ser_t_q;
        mul_b = z2_q;
      end
      OP_T_DIV: begin
        mul_a = mul_q[63:32];
        mul_b = recip;
      end
      OP_A_MUL: begin
        mul_a = 32'(5'd24 - k_q);
        mul_b = Ln2Q32;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    unique case (cmd_i.op)
      OP_ZDIV: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, 31'(x_q - 31'h4000_0000), 32'd0};
        div_dsr   = 32'(x_q) + 32'h4000_0000;
      end
      OP_MEAN_DIV: begin
        div_start = 1'b1;
        div_dvd   = acc_q;
        div_dsr   = 32'(cnt_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, term_q};
    lnm     = {ser_sum_q, 1'b0};
    a_val   = {1'b0, mul_q[36:0]};
    ln_diff = a_val - 38'(lnm) + 38'd128;
    err_fin = err_q;
    if (err_q == ST_OK && kind_q == KIND_CCE && hot_q != 2'd1) err_fin = ST_ONE_HOT;
    need_mean = (err_fin == ST_OK) && (cnt_q <= CountW'(MaxElements)) && (kind_q != KIND_CCE);
    round_up  = {rem, 1'b0} >= 33'(cnt_q);
    val = (kind_q == KIND_CCE) ? {1'b0, acc_q} : ({1'b0, quot} + 65'(round_up));
    if (err_fin != ST_OK) begin
      res_loss = '0;
      res_st   = err_fin;
    end else if (cnt_q > CountW'(MaxElements)) begin
      res_loss = ValueMax;
      res_st   = ST_OVF;
    end else if (val > 65'(ValueMax)) begin
      res_loss = ValueMax;
      res_st   = ST_OVF;
    end else begin
      res_loss = val[55:0];
      res_st   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_cfg_q  <= KIND_MSE;
      err_q       <= ST_OK;
      hot_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) kind_cfg_q <= lve_kind_e'(cfg_wdata_i);
      if (cmd_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_ACCEPT: begin
          if (ce_in) begin
            if (signed'(predicted_i) < 32'sd0 || signed'(predicted_i) > 32'sd16777216) begin
              err_q <= ST_PRED;
            end else if (signed'(expected_i) != 32'sd0 && !in_t_one && err_q == ST_OK) begin
              err_q <= ST_TARGET;
            end
            if (in_t_one && hot_q != 2'd2) hot_q <= hot_q + 2'd1;
          end
        end
        OP_ACCUM: begin
          acc_q <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
          if (cnt_q <= CountW'(MaxElements)) cnt_q <= cnt_q + 1'b1;
        end
        OP_RESULT: begin
          err_q       <= ST_OK;
          hot_q       <= '0;
          acc_q       <= '0;
          cnt_q       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        kind_q <= kind_cfg_q;
        p_q    <= predicted_i;
        t_q    <= expected_i;
        last_q <= last_i;
      end
      OP_MSE_TERM:  term_q <= 64'((65'(mul_q) + 65'h80_0000) >> 24);
      OP_ZERO_TERM: term_q <= '0;
      OP_LN_PREP: begin
        k_q <= k_d;
        x_q <= 31'(q) << (5'd30 - k_d);
      end
      OP_LN_INIT: begin
        z_q       <= quot[30:0];
        ser_t_q   <= {1'b0, quot[30:0]};
        ser_sum_q <= {2'b0, quot[30:0]};
        n_q       <= 5'd3;
      end
      OP_SQ_CAP: z2_q    <= mul_q[63:32];
      OP_T_DIV:  ser_t_q <= mul_q[63:32];
      OP_T_ACC: begin
        ser_sum_q <= ser_sum_q + 33'(t_quo);
        n_q       <= n_q + 5'd2;
      end
      OP_LN_TERM: term_q <= (a_val > 38'(lnm)) ? 64'(ln_diff >> 8) : 64'd0;
      OP_RESULT: begin
        out_loss_q <= res_loss;
        out_st_q   <= res_st;
      end
      default: begin
      end
    endcase
  end

  assign status_o.div_busy    = div_busy;
  assign status_o.item_last   = last_q;
  assign status_o.log_path    = (kind_q == KIND_BCE) || (kind_q == KIND_CCE && tgt_one);
  assign status_o.mse_path    = (kind_q == KIND_MSE) || (kind_q == KIND_RSV);
  assign status_o.series_last = n_q == SeriesLastN;
  assign status_o.need_mean   = need_mean;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign loss_value_o  = out_loss_q;
  assign status_code_o = out_st_q;

endmodule

// ===== src/lve_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lve_controller
// Sequencer for item intake, term evaluation, accumulation and result.
// ----------------------------------------------------------------------------
module lve_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lve_pkg::lve_status_t status_i,
  output lve_pkg::lve_cmd_t    cmd_o
);
  import lve_pkg::*;

  lve_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (status_i.mse_path) begin
          state_d = S_MSE_MUL;
        end else if (status_i.log_path) begin
          state_d = S_LN_PREP;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_MSE_MUL:   state_d = S_MSE_TERM;
      S_MSE_TERM:  state_d = S_ACCUM;
      S_ZERO:      state_d = S_ACCUM;
      S_LN_PREP:   state_d = S_ZDIV;
      S_ZDIV:      state_d = S_ZWAIT;
      S_ZWAIT:     if (!status_i.div_busy) state_d = S_LN_INIT;
      S_LN_INIT:   state_d = S_SQ_MUL;
      S_SQ_MUL:    state_d = S_SQ_CAP;
      S_SQ_CAP:    state_d = S_T_MUL;
      S_T_MUL:     state_d = S_T_DIV;
      S_T_DIV:     state_d = S_T_ACC;
      S_T_ACC:     state_d = status_i.series_last ? S_A_MUL : S_T_MUL;
      S_A_MUL:     state_d = S_LN_TERM;
      S_LN_TERM:   state_d = S_ACCUM;
      S_ACCUM:     state_d = status_i.item_last ? S_FINISH : S_IDLE;
      S_FINISH:    state_d = status_i.need_mean ? S_MEAN_DIV : S_RESULT;
      S_MEAN_DIV:  state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: if (!status_i.div_busy) state_d = S_RESULT;
      S_RESULT:    if (status_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_ACCEPT;
      end
      S_MSE_MUL:  cmd_o.op = OP_MSE_MUL;
      S_MSE_TERM: cmd_o.op = OP_MSE_TERM;
      S_ZERO:     cmd_o.op = OP_ZERO_TERM;
      S_LN_PREP:  cmd_o.op = OP_LN_PREP;
      S_ZDIV:     cmd_o.op = OP_ZDIV;
      S_LN_INIT:  cmd_o.op = OP_LN_INIT;
      S_SQ_MUL:   cmd_o.op = OP_SQ_MUL;
      S_SQ_CAP:   cmd_o.op = OP_SQ_CAP;
      S_T_MUL:    cmd_o.op = OP_T_MUL;
      S_T_DIV:    cmd_o.op = OP_T_DIV;
      S_T_ACC:    cmd_o.op = OP_T_ACC;
      S_A_MUL:    cmd_o.op = OP_A_MUL;
      S_LN_TERM:  cmd_o.op = OP_LN_TERM;
      S_ACCUM:    cmd_o.op = OP_ACCUM;
      S_MEAN_DIV: cmd_o.op = OP_MEAN_DIV;
      S_RESULT:   if (status_i.out_free) cmd_o.op = OP_RESULT;
      default: begin
      end
    endcase
  end

endmodule

// ===== src/loss_vector_evaluator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_vector_evaluator_top
// Streaming loss (MSE, binary or categorical cross-entropy) over a Q8.24 vector.
// ----------------------------------------------------------------------------
// Throughput: one word at a time; MSE words take a squaring multiply and a
//   rounding step, cross-entropy words with a log term a serial divide of the
//   log argument and 12 series steps, other categorical words a zero term.
// After the last word come the finish step, the mean divide if needed, and the result.
// The result register frees intake while a result waits for the sink.
// Reset: asynchronous, clears the sums, counts, errors and loss kind (MSE).
module loss_vector_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,    // loss_kind
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] predicted, [63:32] expected
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [55:0] loss_value, [58:56] status, zero pad
);
  import lve_pkg::*;

  lve_cmd_t    cmd;
  lve_status_t stat;
  logic [55:0] loss;
  logic [2:0]  st_code;

  lve_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (stat),
    .cmd_o      (cmd)
  );

  lve_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .predicted_i   (s_axis_tdata[31:0]),
    .expected_i    (s_axis_tdata[63:32]),
    .last_i        (s_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .loss_value_o  (loss),
    .status_code_o (st_code)
  );

  assign m_axis_tdata = {5'd0, st_code, loss};

  a_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("intake open while a word is in work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_code != ST_OK && st_code != ST_OVF |-> loss == '0)
    else $error("validation error with nonzero loss");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_code == ST_OVF |-> loss == ValueMax)
    else $error("overflow without saturation");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> st_code <= ST_OVF)
    else $error("status code out of range");

endmodule
